FILE: rtl/core/rwl_pkg.sv
// Shared codes and types for the reader-writer lock unit.
package rwl_pkg;

  localparam int REQ_W = 3;
  localparam int OC_W  = 3;

  localparam logic [REQ_W-1:0] REQ_ENTER_READ  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ENTER_WRITE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EXIT_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EXIT_WRITE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DOWNGRADE   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TRY_UPGRADE = 3'd5;

  localparam logic [OC_W-1:0] OC_READ     = 3'd0;
  localparam logic [OC_W-1:0] OC_WRITE    = 3'd1;
  localparam logic [OC_W-1:0] OC_BLOCKED  = 3'd2;
  localparam logic [OC_W-1:0] OC_REFUSED  = 3'd3;
  localparam logic [OC_W-1:0] OC_RELEASED = 3'd4;
  localparam logic [OC_W-1:0] OC_ERROR    = 3'd5;

  typedef struct packed {
    logic push;
    logic pop;
  } rwl_qctl_t;

endpackage

FILE: rtl/core/reader_writer_lock_unit.sv
// Reader-writer lock unit: request decoder, handoff sequencer and wait queues.
// The request is registered, then decided in S_DECIDE once the output is free;
// a release may then wake every queued reader (up to WAIT_QUEUE_DEPTH) or one
// writer, one result a cycle from the shared output register while m_tready is
// high; s_tready is high only while the sequencer is idle.
// Reset (rst, synchronous): lock free, no readers, both wait queues empty;
// queue entries are undefined until written.
module reader_writer_lock_unit #(
  parameter int THREAD_ID_BITS   = 6,
  parameter int WAIT_QUEUE_DEPTH = 16,
  parameter int MAX_READERS      = 255
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata: [2:0] req_type, then thread_id (THREAD_ID_BITS), zero padded
  input  logic [((rwl_pkg::REQ_W + THREAD_ID_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata: target_thread (THREAD_ID_BITS), then outcome (3 bits), zero padded
  output logic [((THREAD_ID_BITS + rwl_pkg::OC_W + 7) / 8) * 8 - 1:0] m_tdata,
  output logic m_tlast
);
  import rwl_pkg::*;

  localparam int TB    = THREAD_ID_BITS;
  localparam int OUT_W = ((TB + OC_W + 7) / 8) * 8;
  localparam int RC_W  = $clog2(MAX_READERS + 1);
  localparam int QC_W  = $clog2(WAIT_QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RWAKE  = 3'd2;
  localparam logic [2:0] S_WWAKE  = 3'd3;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [REQ_W-1:0] req_op;
  logic [TB-1:0]   req_tid;

  logic [RC_W-1:0] reader_count;
  logic [RC_W-1:0] reader_count_next;
  logic            write_held;
  logic            write_held_next;
  logic [TB-1:0]   writer_owner;
  logic [TB-1:0]   writer_owner_next;

  rwl_qctl_t       rq_ctl;
  rwl_qctl_t       wq_ctl;
  logic [QC_W-1:0] rq_cnt;
  logic [QC_W-1:0] wq_cnt;
  logic [TB-1:0]   rq_head;
  logic [TB-1:0]   wq_head;

  logic            ov;
  logic [TB-1:0]   o_tid;
  logic [OC_W-1:0] o_oc;
  logic            o_last;
  logic            can_load;
  logic            load;
  logic [TB-1:0]   ld_tid;
  logic [OC_W-1:0] ld_oc;
  logic            ld_last;
  logic            owner;
  logic            rq_full;

  assign s_tready = (state == S_IDLE);
  assign can_load = !ov || m_tready;
  assign m_tvalid = ov;
  assign m_tlast  = o_last;
  assign m_tdata  = OUT_W'({o_oc, o_tid});

  assign owner   = write_held && (writer_owner == req_tid);
  assign rq_full = (rq_cnt >= QC_W'(WAIT_QUEUE_DEPTH)) ||
                   ((int'(rq_cnt) + 2) > MAX_READERS);

  always_comb begin
    state_next        = state;
    reader_count_next = reader_count;
    write_held_next   = write_held;
    writer_owner_next = writer_owner;
    rq_ctl            = '0;
    wq_ctl            = '0;
    load              = 1'b0;
    ld_tid            = req_tid;
    ld_oc             = OC_ERROR;
    ld_last           = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (can_load) begin
          load       = 1'b1;
          state_next = S_IDLE;
          unique case (req_op)
            REQ_ENTER_READ: begin
              if (!write_held) begin
                if (reader_count < RC_W'(MAX_READERS)) begin
                  reader_count_next = reader_count + RC_W'(1);
                  ld_oc             = OC_READ;
                end
              end else if (!owner && !rq_full) begin
                rq_ctl.push = 1'b1;
                ld_oc       = OC_BLOCKED;
              end
            end
            REQ_ENTER_WRITE: begin
              if (!write_held && reader_count == '0) begin
                write_held_next   = 1'b1;
                writer_owner_next = req_tid;
                ld_oc             = OC_WRITE;
              end else if (!owner && wq_cnt < QC_W'(WAIT_QUEUE_DEPTH)) begin
                wq_ctl.push = 1'b1;
                ld_oc       = OC_BLOCKED;
              end
            end
            REQ_EXIT_READ: begin
              if (!write_held && reader_count != '0) begin
                ld_oc = OC_RELEASED;
                if (reader_count > RC_W'(1) || wq_cnt == '0) begin
                  reader_count_next = reader_count - RC_W'(1);
                end else begin
                  // last reader: hand the lock to the first waiting writer
                  reader_count_next = '0;
                  write_held_next   = 1'b1;
                  ld_last           = 1'b0;
                  state_next        = S_WWAKE;
                end
              end
            end
            REQ_EXIT_WRITE: begin
              if (owner) begin
                ld_oc = OC_RELEASED;
                if (rq_cnt != '0) begin
                  write_held_next   = 1'b0;
                  reader_count_next = RC_W'(rq_cnt);
                  ld_last           = 1'b0;
                  state_next        = S_RWAKE;
                end else if (wq_cnt != '0) begin
                  ld_last    = 1'b0;
                  state_next = S_WWAKE;
                end else begin
                  write_held_next = 1'b0;
                end
              end
            end
            REQ_DOWNGRADE: begin
              if (owner) begin
                write_held_next   = 1'b0;
                reader_count_next = RC_W'(rq_cnt) + RC_W'(1);
                ld_oc             = OC_READ;
                if (rq_cnt != '0) begin
                  ld_last    = 1'b0;
                  state_next = S_RWAKE;
                end
              end
            end
            REQ_TRY_UPGRADE: begin
              if (!write_held && reader_count != '0) begin
                if (reader_count > RC_W'(1)) begin
                  ld_oc = OC_REFUSED;
                end else begin
                  reader_count_next = '0;
                  write_held_next   = 1'b1;
                  writer_owner_next = req_tid;
                  ld_oc             = OC_WRITE;
                end
              end
            end
            default: begin
              ld_oc = OC_ERROR;
            end
          endcase
        end
      end
      S_RWAKE: begin
        if (can_load) begin
          load       = 1'b1;
          ld_tid     = rq_head;
          ld_oc      = OC_READ;
          ld_last    = (rq_cnt == QC_W'(1));
          rq_ctl.pop = 1'b1;
          if (rq_cnt == QC_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_WWAKE: begin
        if (can_load) begin
          load              = 1'b1;
          ld_tid            = wq_head;
          ld_oc             = OC_WRITE;
          ld_last           = 1'b1;
          wq_ctl.pop        = 1'b1;
          writer_owner_next = wq_head;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      reader_count <= '0;
      write_held   <= 1'b0;
      writer_owner <= '0;
      ov           <= 1'b0;
    end else begin
      state        <= state_next;
      reader_count <= reader_count_next;
      write_held   <= write_held_next;
      writer_owner <= writer_owner_next;
      if (load) begin
        ov <= 1'b1;
      end else if (m_tready) begin
        ov <= 1'b0;
      end
    end
  end

  // hold the request and the output word; no reset on payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op  <= s_tdata[REQ_W-1:0];
      req_tid <= s_tdata[REQ_W +: TB];
    end
    if (load) begin
      o_tid  <= ld_tid;
      o_oc   <= ld_oc;
      o_last <= ld_last;
    end
  end

  rwl_queue #(
    .DEPTH (WAIT_QUEUE_DEPTH),
    .W     (TB)
  ) u_reader_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rq_ctl),
    .push_data (req_tid),
    .count     (rq_cnt),
    .head_data (rq_head)
  );

  rwl_queue #(
    .DEPTH (WAIT_QUEUE_DEPTH),
    .W     (TB)
  ) u_writer_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (wq_ctl),
    .push_data (req_tid),
    .count     (wq_cnt),
    .head_data (wq_head)
  );

`ifndef SYNTHESIS
  a_no_mixed_hold: assert property (@(posedge clk) disable iff (rst)
    !(write_held && reader_count != '0))
    else $error("lock both write-held and read-held");

  a_rwake_has_waiter: assert property (@(posedge clk) disable iff (rst)
    (state == S_RWAKE) |-> (rq_cnt != '0 && !write_held))
    else $error("reader wake with empty reader queue");

  a_wwake_has_waiter: assert property (@(posedge clk) disable iff (rst)
    (state == S_WWAKE) |-> (wq_cnt != '0 && write_held))
    else $error("writer handoff with empty writer queue");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!ov || m_tready))
    else $error("result word overwritten before it was taken");
`endif

endmodule

FILE: rtl/core/rwl_queue.sv
// Ring FIFO of waiting thread ids with a registered head read.
module rwl_queue #(
  parameter int DEPTH = 16,
  parameter int W     = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rwl_pkg::rwl_qctl_t           ctl,
  input  logic [W-1:0]                 push_data,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [W-1:0]                 head_data
);
  import rwl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail;
  int            tsum;

  always_comb begin
    tsum = int'(head) + int'(count);
    if (tsum >= DEPTH) begin
      tsum = tsum - DEPTH;
    end
    tail = IW'(tsum);
    if (ctl.pop) begin
      head_next = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
    end else begin
      head_next = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (ctl.push) begin
        count <= count + CW'(1);
      end else if (ctl.pop) begin
        count <= count - CW'(1);
      end
    end
  end

  // read from the next head so that head_data shows the new head in the cycle after a pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_data;
    end
    head_data <= mem[head_next];
  end

endmodule
